// ===== sv/becc_pkg.sv =====
`timescale 1ns / 1ps

package becc_pkg;

	localparam int ROWS        = 32;
	localparam int COLS        = 32;
	localparam int MAX_ROW_SET = 6;

	// fixed field widths
	localparam int WORD_W     = 32;
	localparam int ROW_IDX_W  = 5;
	localparam int COL_IDX_W  = 5;
	localparam int S_W        = 3;
	localparam int T_W        = 6;
	localparam int USE_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam int ROW_W  = $clog2(ROWS);
	localparam int CNT_W  = $clog2(ROWS + 1);
	localparam int IDX_W  = CNT_W + 1;
	localparam int NCOL_W = $clog2(COLS + 1);
	localparam int SET_W  = $clog2(MAX_ROW_SET + 1);
	localparam int LVL_W  = (MAX_ROW_SET > 1) ? $clog2(MAX_ROW_SET) : 1;
	localparam int PC_W   = $clog2(WORD_W + 1);
	localparam int CMP_W  = ((PC_W > T_W) ? PC_W : T_W) + 1;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_SET_SIZE    = 2'd0,
		CFG_COLUMN_SET_SIZE = 2'd1,
		CFG_ROWS_USED       = 2'd2,
		CFG_COLS_USED       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [S_W-1:0]   row_set_size;
		logic [T_W-1:0]   column_set_size;
		logic [USE_W-1:0] rows_used;
		logic [USE_W-1:0] cols_used;
	} cfg_t;

	typedef struct packed {
		logic             we;
		logic [ROW_W-1:0] waddr;
		word_t            wdata;
		logic [ROW_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		word_t          a;
		word_t          b;
		logic [T_W-1:0] t;
	} eval_req_t;

	typedef struct packed {
		word_t conj;
		logic  ok;
	} eval_rsp_t;

endpackage

// ===== sv/becc_ram.sv =====
`timescale 1ns / 1ps

module becc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/becc_eval.sv =====
`timescale 1ns / 1ps

// AND of two row words, popcount, and the 1 + count >= t test
module becc_eval (
	input  becc_pkg::eval_req_t req,
	output becc_pkg::eval_rsp_t rsp
);
	import becc_pkg::*;

	function automatic logic [PC_W-1:0] popcount(input word_t w);
		logic [PC_W-1:0] c;
		c = '0;
		for (int i = 0; i < WORD_W; i++) begin
			c = c + PC_W'(w[i]);
		end
		return c;
	endfunction

	word_t           conj;
	logic [PC_W-1:0] cnt;

	assign conj     = req.a & req.b;
	assign cnt      = popcount(conj);
	assign rsp.conj = conj;
	assign rsp.ok   = (CMP_W'(cnt) + CMP_W'(1)) >= CMP_W'(req.t);

endmodule

// ===== sv/becc_seq.sv =====
`timescale 1ns / 1ps

module becc_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  becc_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [becc_pkg::ROW_IDX_W-1:0] row_index,
	input  logic [becc_pkg::WORD_W-1:0]   row_bits,
	input  logic [becc_pkg::COL_IDX_W-1:0] column,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output becc_pkg::ram_req_t            adj_req,
	input  becc_pkg::word_t               adj_rdata,
	output becc_pkg::ram_req_t            cand_req,
	input  becc_pkg::word_t               cand_rdata,
	output becc_pkg::eval_req_t           ev_req,
	input  becc_pkg::eval_rsp_t           ev_rsp
);
	import becc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ULD   = 8'b0000_0010,
		S_SRD   = 8'b0000_0100,
		S_SCHK  = 8'b0000_1000,
		S_PRE   = 8'b0001_0000,
		S_SRCH  = 8'b0010_0000,
		S_SEVAL = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t               state_q, state_d;
	logic                 out_valid_q, found_q;
	logic                 res_q;
	logic [ROW_W-1:0]     u_q;
	logic [COL_IDX_W-1:0] v_q;
	logic [SET_W-1:0]     s_q;
	logic [T_W-1:0]       t_q;
	logic [CNT_W-1:0]     m_q;
	word_t                colmask_q;
	logic [ROW_W-1:0]     scan_i_q;
	logic [CNT_W-1:0]     ncand_q;
	logic [LVL_W-1:0]     d_q;
	logic [CNT_W-1:0]     idx_q [MAX_ROW_SET];
	word_t                acc_q [MAX_ROW_SET];

	logic                 slot_free, accept, load_out, load_val;
	logic                 u_bad, is_cand, past_end;
	logic [SET_W-1:0]     s_eff;
	logic [CNT_W-1:0]     m_eff;
	logic [NCOL_W-1:0]    n_eff;
	word_t                colmask;
	logic [IDX_W-1:0]     need;
	logic [CNT_W-1:0]     cur_idx;
	logic [LVL_W-1:0]     d_up, d_dn;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign found     = found_q;

	assign u_bad = int'(row_index) >= ROWS;
	assign s_eff = (int'(cfg.row_set_size) > MAX_ROW_SET) ? SET_W'(MAX_ROW_SET)
	                                                      : SET_W'(cfg.row_set_size);
	assign m_eff = (int'(cfg.rows_used) > ROWS) ? CNT_W'(ROWS) : CNT_W'(cfg.rows_used);
	assign n_eff = (int'(cfg.cols_used) > COLS) ? NCOL_W'(COLS) : NCOL_W'(cfg.cols_used);

	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			colmask[j] = (j < int'(n_eff)) && (j != int'(column));
		end
	end

	// rows still needed below the current level
	assign need     = IDX_W'(s_q) - IDX_W'(1) - IDX_W'(d_q);
	assign cur_idx  = idx_q[d_q];
	assign past_end = (IDX_W'(cur_idx) + need) > IDX_W'(ncand_q);
	assign is_cand  = (scan_i_q != u_q) && adj_rdata[v_q];
	assign d_up     = d_q + LVL_W'(1);
	assign d_dn     = d_q - LVL_W'(1);

	always_comb begin
		adj_req.we    = accept && !mode && !u_bad;
		adj_req.waddr = ROW_W'(row_index);
		adj_req.wdata = row_bits;
		adj_req.raddr = (state_q == S_IDLE) ? ROW_W'(row_index) : scan_i_q;

		cand_req.we    = (state_q == S_SCHK) && is_cand;
		cand_req.waddr = ncand_q[ROW_W-1:0];
		cand_req.wdata = adj_rdata;
		cand_req.raddr = cur_idx[ROW_W-1:0];

		ev_req.t = t_q;
		if (state_q == S_ULD) begin
			ev_req.a = adj_rdata;
			ev_req.b = colmask_q;
		end else begin
			ev_req.a = acc_q[d_q];
			ev_req.b = cand_rdata;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		load_val = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!mode) begin
						load_out = 1'b1;
					end else if (u_bad || s_eff == '0) begin
						state_d = S_FIN;
					end else begin
						state_d = S_ULD;
					end
				end
			end
			S_ULD: begin
				if (!ev_rsp.ok) begin
					state_d = S_FIN;
				end else if (m_q == '0) begin
					state_d = S_PRE;
				end else begin
					state_d = S_SRD;
				end
			end
			S_SRD:  state_d = S_SCHK;
			S_SCHK: state_d = (CNT_W'(scan_i_q) + CNT_W'(1) == m_q) ? S_PRE : S_SRD;
			S_PRE: begin
				if (IDX_W'(ncand_q) + IDX_W'(1) < IDX_W'(s_q) || s_q == SET_W'(1)) begin
					state_d = S_FIN;
				end else begin
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (!past_end) begin
					state_d = S_SEVAL;
				end else if (d_q == '0) begin
					state_d = S_FIN;
				end
			end
			S_SEVAL: begin
				if (ev_rsp.ok && need == IDX_W'(1)) begin
					state_d = S_FIN;
				end else begin
					state_d = S_SRCH;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					load_out = 1'b1;
					load_val = res_q;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q <= load_val;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept && mode) begin
					u_q       <= ROW_W'(row_index);
					v_q       <= column;
					s_q       <= s_eff;
					t_q       <= cfg.column_set_size;
					m_q       <= m_eff;
					colmask_q <= colmask;
					scan_i_q  <= '0;
					ncand_q   <= '0;
					res_q     <= 1'b0;
				end
			end
			S_ULD: begin
				acc_q[0] <= ev_rsp.conj;
			end
			S_SRD: begin
			end
			S_SCHK: begin
				if (is_cand) begin
					ncand_q <= ncand_q + CNT_W'(1);
				end
				scan_i_q <= scan_i_q + ROW_W'(1);
			end
			S_PRE: begin
				// a single row set needs only row u, already checked
				res_q    <= (s_q == SET_W'(1)) &&
				            !(IDX_W'(ncand_q) + IDX_W'(1) < IDX_W'(s_q));
				d_q      <= '0;
				idx_q[0] <= '0;
			end
			S_SRCH: begin
				if (past_end && d_q != '0) begin
					d_q         <= d_dn;
					idx_q[d_dn] <= idx_q[d_dn] + CNT_W'(1);
				end
			end
			S_SEVAL: begin
				if (!ev_rsp.ok) begin
					idx_q[d_q] <= cur_idx + CNT_W'(1);
				end else if (need == IDX_W'(1)) begin
					res_q <= 1'b1;
				end else begin
					acc_q[d_up] <= ev_rsp.conj;
					idx_q[d_up] <= cur_idx + CNT_W'(1);
					d_q         <= d_up;
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// search depth stays below the last level of the row set
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH || state_q == S_SEVAL) |-> (IDX_W'(d_q) + IDX_W'(2) <= IDX_W'(s_q)))
		else $error("search depth out of range");

	// candidate count never runs ahead of the rows scanned
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCHK) |-> (ncand_q <= CNT_W'(scan_i_q)))
		else $error("candidate count exceeds scanned rows");

	// a row write answers zero on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !mode) |=> (out_valid_q && !found_q))
		else $error("row write did not return a zero beat");

	// nothing is accepted while a query is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> !($past(accept)))
		else $error("beat accepted during a query");

endmodule

// ===== sv/biclique_edge_closure_check.sv =====
`timescale 1ns / 1ps
// Row write: result beat is registered in the cycle after acceptance.
// Query: rows adjacent to column v are gathered, then candidate rows are ANDed through the
// shared popcount unit with backtracking; s = 0 or a row u with too few columns answers without a search.
// One item at a time; the next is accepted once the result beat is out or being taken.
// Reset clears sequencer, output beat and config registers to defaults; adjacency rows stay undefined.
module biclique_edge_closure_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [becc_pkg::ROW_IDX_W-1:0]  row_index,
	input  logic [becc_pkg::WORD_W-1:0]     row_bits,
	input  logic [becc_pkg::COL_IDX_W-1:0]  column,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [becc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [becc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import becc_pkg::*;

	cfg_t      cfg_q;
	ram_req_t  adj_req, cand_req;
	word_t     adj_rdata, cand_rdata;
	eval_req_t ev_req;
	eval_rsp_t ev_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_set_size    <= S_W'(2);
			cfg_q.column_set_size <= T_W'(2);
			cfg_q.rows_used       <= USE_W'(32);
			cfg_q.cols_used       <= USE_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROW_SET_SIZE:    cfg_q.row_set_size    <= cfg_data[S_W-1:0];
				CFG_COLUMN_SET_SIZE: cfg_q.column_set_size <= cfg_data[T_W-1:0];
				CFG_ROWS_USED:       cfg_q.rows_used       <= cfg_data[USE_W-1:0];
				CFG_COLS_USED:       cfg_q.cols_used       <= cfg_data[USE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	becc_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_adj_ram (
		.clk   (clk),
		.we    (adj_req.we),
		.waddr (adj_req.waddr),
		.wdata (adj_req.wdata),
		.raddr (adj_req.raddr),
		.rdata (adj_rdata)
	);

	// candidate rows adjacent to v, packed in scan order
	becc_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_cand_ram (
		.clk   (clk),
		.we    (cand_req.we),
		.waddr (cand_req.waddr),
		.wdata (cand_req.wdata),
		.raddr (cand_req.raddr),
		.rdata (cand_rdata)
	);

	becc_eval u_eval (
		.req (ev_req),
		.rsp (ev_rsp)
	);

	becc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.row_index  (row_index),
		.row_bits   (row_bits),
		.column     (column),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.adj_req    (adj_req),
		.adj_rdata  (adj_rdata),
		.cand_req   (cand_req),
		.cand_rdata (cand_rdata),
		.ev_req     (ev_req),
		.ev_rsp     (ev_rsp)
	);

endmodule
